### src/mjdp_pkg.sv
package mjdp_pkg;

  // List capacity and derived widths
  localparam int unsigned MAX_NONZEROS = 1024;
  localparam int unsigned IDX_W = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_NONZEROS + 1);

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned PROD_W  = 2 * VAL_W;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned MATCH_W = 11;

  // Accumulator limits
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CMP,
    ST_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
  } entry_t;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;   // zero accumulator and clip flag
    logic mul_en;  // register the product of the operands
    logic acc_en;  // add the registered product
  } mac_ctrl_t;

endpackage

### src/merge_join_dot_product_top.sv
// Sparse vector dot product by merge join.
//
// Input channel (in_valid_i / in_stall_o) carries op_i, position_i, value_i.
// Op load A / load B appends one (position, Q8.8 value) entry to that list;
// entries must arrive in ascending position order. A load into a
// full list is dropped and sets a sticky flag. A compute transaction walks both
// lists and produces one result on the output channel (out_valid_o /
// out_stall_i): Q32.16 dot product clipped to 48 bits, match count, drop flag
// and clip flag. Unused op codes are absorbed with no effect.
// Loads are accepted back to back while idle. A compute steps through FETCH
// and CMP for each non-matching step and through FETCH, CMP and ACC for each
// match (shared multiplier, then a registered saturating add); the memory read
// latency of the two list RAMs sets the per-step pace.
// The input is stalled while a compute is in progress. The result sits in an
// output register; loads are still taken while it waits, but a following
// compute holds at its last step until the receiver takes the earlier result.
// After the result is registered both lists are emptied and the drop flag is
// cleared. Reset empties both lists and clears the flags; list RAM contents
// are not cleared and need no clearing pass.
module merge_join_dot_product_top
  import mjdp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OP_W-1:0]         op_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [ACC_W-1:0] dot_o,
  output logic [MATCH_W-1:0]      matches_res_o,
  output logic                    dropped_o,
  output logic                    saturated_o
);

  state_e state_q, state_d;

  // List storage, one RAM per vector
  entry_t mem_a [MAX_NONZEROS];
  entry_t mem_b [MAX_NONZEROS];
  entry_t rd_a_q, rd_b_q;

  logic [CNT_W-1:0] a_count_q, b_count_q;
  logic [CNT_W-1:0] ia_q, ia_d, ib_q, ib_d;
  logic [CNT_W-1:0] matches_q, matches_d;
  logic             overflow_q;

  logic      wr_a, wr_b, set_ovf, out_load;
  mac_ctrl_t mac_ctrl;
  logic [ACC_W-1:0] mac_acc;
  logic             mac_sat;

  logic                    out_valid_q;
  logic [ACC_W-1:0]        dot_q;
  logic [MATCH_W-1:0]      matches_res_q;
  logic                    dropped_q, saturated_q;

  // Busy for the whole walk
  assign in_stall_o = (state_q != ST_IDLE);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    ia_d      = ia_q;
    ib_d      = ib_q;
    matches_d = matches_q;
    mac_ctrl  = '0;
    wr_a      = 1'b0;
    wr_b      = 1'b0;
    set_ovf   = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (op_i)
            OP_LOAD_A: begin
              if (a_count_q < CNT_W'(MAX_NONZEROS)) wr_a = 1'b1;
              else set_ovf = 1'b1;
            end
            OP_LOAD_B: begin
              if (b_count_q < CNT_W'(MAX_NONZEROS)) wr_b = 1'b1;
              else set_ovf = 1'b1;
            end
            OP_COMPUTE: begin
              state_d        = ST_FETCH;
              ia_d           = '0;
              ib_d           = '0;
              matches_d      = '0;
              mac_ctrl.clear = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        // RAM reads at ia/ib are in flight this cycle
        if (ia_q >= a_count_q || ib_q >= b_count_q) state_d = ST_DONE;
        else state_d = ST_CMP;
      end
      ST_CMP: begin
        if (rd_b_q.pos < rd_a_q.pos) begin
          ib_d    = ib_q + 1'b1;
          state_d = ST_FETCH;
        end else if (rd_a_q.pos < rd_b_q.pos) begin
          ia_d    = ia_q + 1'b1;
          state_d = ST_FETCH;
        end else begin
          mac_ctrl.mul_en = 1'b1;
          state_d         = ST_ACC;
        end
      end
      ST_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        matches_d       = matches_q + 1'b1;
        ia_d            = ia_q + 1'b1;
        ib_d            = ib_q + 1'b1;
        state_d         = ST_FETCH;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ia_q      <= '0;
      ib_q      <= '0;
      matches_q <= '0;
    end else begin
      state_q   <= state_d;
      ia_q      <= ia_d;
      ib_q      <= ib_d;
      matches_q <= matches_d;
    end
  end

  // List fill counts and sticky drop flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_count_q  <= '0;
      b_count_q  <= '0;
      overflow_q <= 1'b0;
    end else if (out_load) begin
      a_count_q  <= '0;
      b_count_q  <= '0;
      overflow_q <= 1'b0;
    end else begin
      if (wr_a) a_count_q <= a_count_q + 1'b1;
      if (wr_b) b_count_q <= b_count_q + 1'b1;
      if (set_ovf) overflow_q <= 1'b1;
    end
  end

  // List RAMs: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (wr_a) mem_a[a_count_q[IDX_W-1:0]] <= '{pos: position_i, val: value_i};
    rd_a_q <= mem_a[ia_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) mem_b[b_count_q[IDX_W-1:0]] <= '{pos: position_i, val: value_i};
    rd_b_q <= mem_b[ib_q[IDX_W-1:0]];
  end

  mjdp_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .a_val_i (rd_a_q.val),
    .b_val_i (rd_b_q.val),
    .acc_o   (mac_acc),
    .sat_o   (mac_sat)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      dot_q         <= mac_acc;
      matches_res_q <= MATCH_W'(matches_q);
      dropped_q     <= overflow_q;
      saturated_q   <= mac_sat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dot_o         = dot_q;
  assign matches_res_o = matches_res_q;
  assign dropped_o     = dropped_q;
  assign saturated_o   = saturated_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_count_q <= CNT_W'(MAX_NONZEROS) && b_count_q <= CNT_W'(MAX_NONZEROS))
    else $error("list count above capacity");

  cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMP |-> (ia_q < a_count_q && ib_q < b_count_q))
    else $error("compare step past end of a list");

  matches_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> (matches_q <= ia_q && matches_q <= ib_q))
    else $error("match count exceeds walk position");

  clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (a_count_q == '0 && b_count_q == '0 && !overflow_q && out_valid_q))
    else $error("lists not emptied after result");

  no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !(wr_a || wr_b || set_ovf))
    else $error("list written during compute");

endmodule

### src/mjdp_mac.sv
module mjdp_mac
  import mjdp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctrl_t               ctrl_i,
  input  logic signed [VAL_W-1:0] a_val_i,
  input  logic signed [VAL_W-1:0] b_val_i,
  output logic [ACC_W-1:0]        acc_o,
  output logic                    sat_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]         acc_q, acc_d;
  logic                     sat_q, sat_d;
  logic [ACC_W:0]           sum;

  // One guard bit: overflow when the top two bits disagree
  assign sum = {acc_q[ACC_W-1], acc_q}
             + {{(ACC_W+1-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    sat_d = sat_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
      sat_d = 1'b0;
    end else if (ctrl_i.acc_en) begin
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        acc_d = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        sat_d = 1'b1;
      end else begin
        acc_d = sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= a_val_i * b_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      sat_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      sat_q <= sat_d;
    end
  end

  assign acc_o = acc_q;
  assign sat_o = sat_q;

endmodule

### sim/tb_merge_join_dot_product_top.sv
module tb_merge_join_dot_product_top;
  import mjdp_pkg::*;

  // Op code 3 is absorbed by the block without effect
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  // Accumulator clip limits as 64-bit signed numbers
  localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;

  // One result transaction as it should appear on the output channel
  typedef struct {
    logic [ACC_W-1:0]   dot;
    logic [MATCH_W-1:0] match_cnt;
    logic               dropped;
    logic               saturated;
  } dot_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [OP_W-1:0]         op_i;
  logic [POS_W-1:0]        position_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [ACC_W-1:0] dot_o;
  logic [MATCH_W-1:0]      matches_res_o;
  logic                    dropped_o;
  logic                    saturated_o;

  // Shadow copy of the two lists and the sticky drop flag
  entry_t      list_a[$];
  entry_t      list_b[$];
  logic        drop_seen;
  // Dot products still owed by the block, oldest first
  dot_result_t dot_expect_q[$];

  int unsigned errors;
  int unsigned items_sent;    // accepted transactions, op 3 excluded
  int unsigned in_idle_pct;   // chance of a sender bubble per cycle
  int unsigned out_idle_pct;  // chance of a receiver stall per cycle
  int unsigned stall_hold;    // cycles of forced receiver stall left

  merge_join_dot_product_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dot_o        (dot_o),
    .matches_res_o(matches_res_o),
    .dropped_o    (dropped_o),
    .saturated_o  (saturated_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Merge walk over both shadow lists. Advances the side with the smaller
  // position (unsigned compare), both sides on a hit. Works the same on
  // unsorted lists or repeated positions. Sum clips after every add.
  function automatic dot_result_t merge_walk();
    dot_result_t res;
    int unsigned ia;
    int unsigned ib;
    int unsigned hits;
    longint      acc;
    logic        clipped;
    ia      = 0;
    ib      = 0;
    hits    = 0;
    acc     = 0;
    clipped = 1'b0;
    while (ia < list_a.size() && ib < list_b.size()) begin
      if (list_b[ib].pos < list_a[ia].pos) begin
        ib++;
      end else if (list_a[ia].pos < list_b[ib].pos) begin
        ia++;
      end else begin
        acc += longint'($signed(list_a[ia].val)) * longint'($signed(list_b[ib].val));
        if (acc > ACC_HI) begin
          acc     = ACC_HI;
          clipped = 1'b1;
        end else if (acc < ACC_LO) begin
          acc     = ACC_LO;
          clipped = 1'b1;
        end
        hits++;
        ia++;
        ib++;
      end
    end
    res.dot       = acc[ACC_W-1:0];
    res.match_cnt = hits[MATCH_W-1:0];
    res.dropped   = drop_seen;
    res.saturated = clipped;
    return res;
  endfunction

  // Applies one accepted input transaction to the shadow state
  function automatic void predict_transaction(input logic [OP_W-1:0]         op,
                                              input logic [POS_W-1:0]        pos,
                                              input logic signed [VAL_W-1:0] val);
    case (op)
      OP_LOAD_A: begin
        if (list_a.size() < MAX_NONZEROS) list_a.push_back('{pos: pos, val: val});
        else drop_seen = 1'b1;
      end
      OP_LOAD_B: begin
        if (list_b.size() < MAX_NONZEROS) list_b.push_back('{pos: pos, val: val});
        else drop_seen = 1'b1;
      end
      OP_COMPUTE: begin
        dot_expect_q.push_back(merge_walk());
        list_a.delete();
        list_b.delete();
        drop_seen = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one transaction per call, driven at the falling edge and held
  // until the block takes it. Valid stays high from one call to the next
  // unless a bubble is drawn, so back-to-back transfers happen.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [OP_W-1:0]         op,
                           input logic [POS_W-1:0]        pos,
                           input logic signed [VAL_W-1:0] val);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i       = op;
    position_i = pos;
    value_i    = val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_transaction(op, pos, val);
    if (op != OP_NOP) items_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall drawn at the falling edge; a forced hold-off wins
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i = 1'b0;
    end else if (stall_hold != 0) begin
      out_stall_i = 1'b1;
      stall_hold--;
    end else begin
      out_stall_i = ($urandom_range(0, 99) < out_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Every result taken by the receiver is matched against the oldest prediction
  always @(posedge clk_i) begin
    dot_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (dot_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got dot %h matches %0d",
                 $time, dot_o, matches_res_o);
        errors++;
      end else begin
        want = dot_expect_q.pop_front();
        check_field("dot", want.dot, $unsigned(dot_o));
        check_field("matches_res", want.match_cnt, matches_res_o);
        check_field("dropped", want.dropped, dropped_o);
        check_field("saturated", want.saturated, saturated_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Compute with both lists empty, then with only list A, then only list B filled
  task automatic test_empty_lists();
    send_item(OP_COMPUTE, '0, '0);
    send_item(OP_LOAD_A, 32'd7, 16'sh0100);
    send_item(OP_COMPUTE, '0, '0);
    send_item(OP_LOAD_B, 32'd7, 16'sh0100);
    send_item(OP_COMPUTE, 32'hFFFF_FFFF, 16'shFFFF);
  endtask

  // Extreme positions and values; a position with the top bit set must sort
  // above a small one, i.e. the compare is unsigned. A zero value hits too.
  task automatic test_field_extremes();
    send_item(OP_LOAD_A, 32'h0000_0000, -16'sd32768);
    send_item(OP_LOAD_B, 32'h0000_0000, -16'sd32768);
    send_item(OP_LOAD_A, 32'h0000_0005, 16'sh0180);
    send_item(OP_LOAD_A, 32'h7FFF_FFFF, 16'sh0000);
    send_item(OP_LOAD_B, 32'h7FFF_FFFF, 16'sh0001);
    send_item(OP_LOAD_A, 32'h8000_0000, 16'sh7FFF);
    send_item(OP_LOAD_B, 32'h8000_0000, -16'sd32768);
    send_item(OP_LOAD_A, 32'hFFFF_FFFF, -16'sd32768);
    send_item(OP_LOAD_B, 32'hFFFF_FFFF, 16'sh7FFF);
    send_item(OP_COMPUTE, '0, '0);
  endtask

  // Op 3 between loads must change nothing
  task automatic test_unused_op();
    send_item(OP_LOAD_A, 32'd3, 16'sh0100);
    send_item(OP_NOP, 32'hFFFF_FFFF, 16'shFFFF);
    send_item(OP_LOAD_B, 32'd3, -16'sh0100);
    send_item(OP_NOP, '0, '0);
    send_item(OP_COMPUTE, '0, '0);
  endtask

  // Out-of-order positions in list A and repeated positions in both lists
  task automatic test_unordered_lists();
    send_item(OP_LOAD_A, 32'd9, 16'sh0200);
    send_item(OP_LOAD_A, 32'd4, 16'sh0300);
    send_item(OP_LOAD_A, 32'd4, -16'sh0040);
    send_item(OP_LOAD_A, 32'd12, 16'sh1000);
    send_item(OP_LOAD_B, 32'd4, 16'sh0100);
    send_item(OP_LOAD_B, 32'd4, 16'sh0500);
    send_item(OP_LOAD_B, 32'd9, -16'sh0700);
    send_item(OP_LOAD_B, 32'd12, 16'sh0011);
    send_item(OP_COMPUTE, '0, '0);
  endtask

  // Full lists: loads past capacity are dropped and flagged; every position
  // hits, so the match count needs its top bit. The largest possible sum
  // (capacity times 2^30) stays below the 48-bit limit, so no clip occurs.
  // The second round fills exactly to capacity, so the flag must be clear.
  task automatic test_list_full();
    int unsigned k;
    for (k = 0; k < MAX_NONZEROS + 1; k++) send_item(OP_LOAD_A, k, -16'sd32768);
    for (k = 0; k < MAX_NONZEROS + 2; k++) send_item(OP_LOAD_B, k, -16'sd32768);
    send_item(OP_COMPUTE, '0, '0);
    for (k = 0; k < MAX_NONZEROS; k++) begin
      send_item(OP_LOAD_A, k, 16'sh7FFF);
      send_item(OP_LOAD_B, k, -16'sd32768);
    end
    send_item(OP_COMPUTE, '0, '0);
  endtask

  // Receiver holds off for a long stretch while several computes queue up:
  // the result register fills, the next compute parks, the input stalls.
  task automatic test_backpressure();
    int unsigned n;
    int unsigned k;
    stall_hold = 300;
    for (n = 0; n < 4; n++) begin
      for (k = 0; k < 3; k++) begin
        send_item(OP_LOAD_A, 32'd10 * n + k, VAL_W'($urandom()));
        send_item(OP_LOAD_B, 32'd10 * n + 2 * k, VAL_W'($urandom()));
      end
      send_item(OP_COMPUTE, '0, '0);
    end
  endtask

  // Random batches: mostly short sorted lists drawn from a shared window so
  // that positions collide; some batches unsorted with repeats, op 3 noise
  // sprinkled in, now and then a longer list.
  task automatic test_random_batches(input int unsigned n_items);
    int unsigned      goal;
    int unsigned      n_a;
    int unsigned      n_b;
    logic             sorted;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] pa;
    logic [POS_W-1:0] pb;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      n_a    = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      n_b    = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      sorted = ($urandom_range(0, 9) != 0);
      start  = $urandom();
      if (start > 32'hFFFF_F000) start = 32'hFFFF_F000;
      pa = start;
      pb = start;
      while (n_a + n_b != 0) begin
        if ($urandom_range(0, 9) == 0) send_item(OP_NOP, $urandom(), VAL_W'($urandom()));
        if (n_b == 0 || (n_a != 0 && $urandom_range(0, 1) == 1)) begin
          send_item(OP_LOAD_A, sorted ? pa : start + $urandom_range(0, 15),
                    VAL_W'($urandom()));
          pa += $urandom_range(1, 3);
          n_a--;
        end else begin
          send_item(OP_LOAD_B, sorted ? pb : start + $urandom_range(0, 15),
                    VAL_W'($urandom()));
          pb += $urandom_range(1, 3);
          n_b--;
        end
      end
      send_item(OP_COMPUTE, $urandom(), VAL_W'($urandom()));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    op_i         = OP_LOAD_A;
    position_i   = '0;
    value_i      = '0;
    out_stall_i  = 1'b0;
    drop_seen    = 1'b0;
    errors       = 0;
    items_sent   = 0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    stall_hold   = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_lists();
    test_field_extremes();
    test_unused_op();
    test_unordered_lists();
    test_list_full();
    test_backpressure();

    // Sender sparse / receiver busy, then the reverse, then full rate
    in_idle_pct  = 36;
    out_idle_pct = 72;
    test_random_batches(217);
    in_idle_pct  = 72;
    out_idle_pct = 36;
    test_random_batches(217);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_batches(216);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (dot_expect_q.size() != 0) @(posedge clk_i);
    // Loads give no result; keep watching the output so that a stray one would show
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("merge_join_dot_product_top: match");
    end else begin
      $display("merge_join_dot_product_top: mismatch");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("merge_join_dot_product_top: mismatch");
    $finish;
  end

endmodule
